### src/sabal_pkg.sv
// ----------------------------------------------------------------------------
// sabal_pkg - shared types and constants of the skyline atlas block allocator
// word layouts of both channels, register indexes, operation codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sabal_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int BLK_W     = 9;
  localparam int COL_OUT_W = 8;
  localparam int ROW_OUT_W = 9;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] ATLAS_WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] ATLAS_HEIGHT_RST = 9'd256;

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [BLK_W-1:0] block_width;
    logic [BLK_W-1:0] block_height;
  } in_word_t;

  typedef struct packed {
    logic                 granted;
    logic [COL_OUT_W-1:0] column_start;
    logic [ROW_OUT_W-1:0] row_start;
  } out_word_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### src/sabal_ram.sv
// ----------------------------------------------------------------------------
// sabal_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sabal_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/sabal_seq.sv
// ----------------------------------------------------------------------------
// sabal_seq - skyline scan sequencer
// walks the column fill ram one column a cycle through a shared compare unit,
// picks the lowest window, raises its columns and runs the clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sabal_seq #(
  parameter int MAX_COLUMNS = sabal_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = sabal_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sabal_pkg::CFG_W-1:0] atlas_width,
  input  logic [sabal_pkg::CFG_W-1:0] atlas_height,
  input  logic                       cmd_valid,
  input  sabal_pkg::in_word_t        cmd,
  output logic                       cmd_ready,
  output logic                       res_valid,
  output sabal_pkg::out_word_t       res,
  input  logic                       res_ready
);

  import sabal_pkg::*;

  localparam int AW    = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int CW_W  = max_int(max_int(CNT_W, BLK_W), CFG_W) + 1;
  localparam int RW_W  = max_int(max_int(ROW_W, BLK_W), CFG_W) + 1;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             clr_op_r, clr_op_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0] mark_r, mark_nxt;
  logic [CNT_W-1:0] best_x_r, best_x_nxt;
  logic [ROW_W-1:0] tallest_r, tallest_nxt;
  logic [ROW_W-1:0] lowest_r, lowest_nxt;
  logic [ROW_W-1:0] best_y_r, best_y_nxt;
  logic [ROW_W-1:0] fill_r, fill_nxt;
  logic [BLK_W-1:0] bw_r, bw_nxt;
  logic [BLK_W-1:0] bh_r, bh_nxt;
  out_word_t        res_r, res_nxt;

  logic [CNT_W-1:0] cols;
  logic [ROW_W-1:0] rows;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] rd_data;

  // compare unit
  logic             k_fail;
  logic             k_top;
  logic             at_end;
  logic             scan_over;
  logic             wr_ok;
  logic [ROW_W-1:0] tall_upd;
  logic [CNT_W-1:0] mark_upd;
  logic [CNT_W-1:0] next_start;
  logic [RW_W-1:0]  top_sum;

  assign cols = (CW_W'(atlas_width) > CW_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS)
                                                           : CNT_W'(atlas_width);
  assign rows = (RW_W'(atlas_height) > RW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                         : ROW_W'(atlas_height);

  assign k_fail     = rd_data >= lowest_r;
  assign k_top      = rd_data >= tallest_r;
  assign tall_upd   = k_top ? rd_data : tallest_r;
  assign mark_upd   = k_top ? idx_r : mark_r;
  assign at_end     = (CW_W'(idx_r) + CW_W'(1)) == (CW_W'(start_r) + CW_W'(bw_r));
  assign next_start = k_fail ? (idx_r + 1'b1) : (mark_upd + 1'b1);
  assign scan_over  = (CW_W'(next_start) + CW_W'(bw_r)) >= CW_W'(cols);
  assign wr_ok      = (CW_W'(idx_r) < (CW_W'(best_x_r) + CW_W'(bw_r))) && (idx_r < cols);
  assign top_sum    = RW_W'(best_y_r) + RW_W'(bh_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    clr_op_nxt  = clr_op_r;
    start_nxt   = start_r;
    mark_nxt    = mark_r;
    best_x_nxt  = best_x_r;
    tallest_nxt = tallest_r;
    lowest_nxt  = lowest_r;
    best_y_nxt  = best_y_r;
    fill_nxt    = fill_r;
    bw_nxt      = bw_r;
    bh_nxt      = bh_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[AW-1:0];
    ram_wdata   = '0;

    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (idx_r == CNT_W'(MAX_COLUMNS - 1)) begin
          if (clr_op_r) begin
            res_nxt    = '0;
            clr_op_nxt = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (cmd_valid) begin
          bw_nxt  = cmd.block_width;
          bh_nxt  = cmd.block_height;
          idx_nxt = '0;
          if (cmd.operation == OP_CLEAR) begin
            clr_op_nxt = 1'b1;
            state_nxt  = S_CLR;
          end else begin
            start_nxt   = '0;
            mark_nxt    = '0;
            tallest_nxt = '0;
            lowest_nxt  = rows;
            best_x_nxt  = '0;
            best_y_nxt  = rows;
            if (cmd.block_width == '0) begin
              // empty window fits everywhere, last start wins at row zero
              if (cols != '0) begin
                best_x_nxt = cols - 1'b1;
                best_y_nxt = '0;
              end
              state_nxt = S_DECIDE;
            end else if (CW_W'(cols) > CW_W'(cmd.block_width)) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_DECIDE;
            end
          end
        end
      end

      S_SCAN: begin
        if (k_fail || at_end) begin
          if (!k_fail) begin
            best_x_nxt = start_r;
            best_y_nxt = tall_upd;
            lowest_nxt = tall_upd;
          end
          // windows up to the blocking column cannot win
          start_nxt   = next_start;
          idx_nxt     = next_start;
          tallest_nxt = '0;
          if (scan_over) begin
            state_nxt = S_DECIDE;
          end
        end else begin
          tallest_nxt = tall_upd;
          mark_nxt    = mark_upd;
          idx_nxt     = idx_r + 1'b1;
        end
      end

      S_DECIDE: begin
        if (top_sum > RW_W'(rows)) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          fill_nxt             = ROW_W'(top_sum);
          idx_nxt              = best_x_r;
          res_nxt.granted      = 1'b1;
          res_nxt.column_start = COL_OUT_W'(best_x_r);
          res_nxt.row_start    = ROW_OUT_W'(best_y_r);
          state_nxt            = S_WRITE;
        end
      end

      S_WRITE: begin
        if (wr_ok) begin
          ram_we    = 1'b1;
          ram_wdata = fill_r;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      idx_r    <= '0;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    mark_r    <= mark_nxt;
    best_x_r  <= best_x_nxt;
    tallest_r <= tallest_nxt;
    lowest_r  <= lowest_nxt;
    best_y_r  <= best_y_nxt;
    fill_r    <= fill_nxt;
    bw_r      <= bw_nxt;
    bh_r      <= bh_nxt;
    res_r     <= res_nxt;
  end

  sabal_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_COLUMNS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |->
      ((CW_W'(idx_r) >= CW_W'(start_r)) &&
       (CW_W'(idx_r) < (CW_W'(start_r) + CW_W'(bw_r)))))
    else $error("scan column outside of current window");

  a_lowest_falls: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && ($past(state_r) == S_SCAN)) |->
      (lowest_r <= $past(lowest_r)))
    else $error("best window height rose during scan");

  a_fill_in_atlas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (RW_W'(fill_r) <= RW_W'(rows)))
    else $error("raised column above atlas height");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && ($past(state_r) == S_CLR)) |-> (res_r == '0))
    else $error("clear gave a nonzero result");

endmodule

### src/skyline_atlas_block_allocator.sv
// ----------------------------------------------------------------------------
// skyline_atlas_block_allocator - skyline rectangle packer for a 2-d atlas
// keeps a fill height per column and places each block over the lowest window
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  operation, block_width, block_height
//   out_     output     out_valid/out_stall granted, column_start, row_start
//   cfg_     input      cfg_we             atlas_width (0), atlas_height (1)
//
// allocate: the scan reads one column fill a cycle, then a decide step refuses
//   the block or, when granted, starts a write pass that raises each covered
//   column before the result is offered; the scan runs longest on strictly
//   falling skylines
// clear: one ram entry zeroed a cycle over all MAX_COLUMNS entries
// reset: a clearing pass over all MAX_COLUMNS entries runs before in_stall drops
// a result waits in the output register, the next word is taken meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skyline_atlas_block_allocator #(
  parameter int MAX_COLUMNS = sabal_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = sabal_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sabal_pkg::in_word_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sabal_pkg::out_word_t           out_data,
  input  logic                           cfg_we,
  input  logic [sabal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sabal_pkg::CFG_W-1:0]     cfg_wdata
);

  import sabal_pkg::*;

  logic [CFG_W-1:0] atlas_width_r, atlas_width_nxt;
  logic [CFG_W-1:0] atlas_height_r, atlas_height_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             cmd_ready;
  logic             res_valid;
  out_word_t        res;
  logic             res_ready;

  always_comb begin
    atlas_width_nxt  = atlas_width_r;
    atlas_height_nxt = atlas_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  atlas_width_nxt  = cfg_wdata;
        CFG_ATLAS_HEIGHT: atlas_height_nxt = cfg_wdata;
        default: begin
          atlas_width_nxt = atlas_width_r;
        end
      endcase
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_width_r  <= ATLAS_WIDTH_RST;
      atlas_height_r <= ATLAS_HEIGHT_RST;
      out_valid_r    <= 1'b0;
    end else begin
      atlas_width_r  <= atlas_width_nxt;
      atlas_height_r <= atlas_height_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  sabal_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .atlas_width  (atlas_width_r),
    .atlas_height (atlas_height_r),
    .cmd_valid    (in_valid),
    .cmd          (in_data),
    .cmd_ready    (cmd_ready),
    .res_valid    (res_valid),
    .res          (res),
    .res_ready    (res_ready)
  );

  assign in_stall  = !cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the skyline atlas block allocator
// drives allocate and clear words through a valid/stall channel with random
// idle bursts on both sides, predicts every placement from a private copy of
// the column fill heights, and checks each result word in order of arrival;
// atlas size registers are rewritten between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sabal_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int NUM_PHASES     = 10;

  class placement_checker;
    int        fill_height [MAX_COLUMNS_DEF];
    int        atlas_cols;
    int        atlas_rows;
    out_word_t expected_grants [$];
    int        mismatches;

    function new();
      foreach (fill_height[i]) fill_height[i] = 0;
      atlas_cols = ATLAS_WIDTH_RST;
      atlas_rows = ATLAS_HEIGHT_RST;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ATLAS_WIDTH) begin
        atlas_cols = val;
      end else begin
        atlas_rows = val;
      end
    endfunction

    function out_word_t place_block(in_word_t w);
      int        cols;
      int        rows;
      int        bw;
      int        bh;
      int        best_x;
      int        best_y;
      int        tallest;
      int        idx;
      int        k;
      bit        fits;
      out_word_t r;
      r    = '0;
      cols = (atlas_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : atlas_cols;
      rows = (atlas_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : atlas_rows;
      if (w.operation == OP_CLEAR) begin
        foreach (fill_height[i]) fill_height[i] = 0;
        return r;
      end
      bw     = w.block_width;
      bh     = w.block_height;
      best_x = 0;
      best_y = rows;
      for (int i = 0; i < cols - bw; i++) begin
        tallest = 0;
        fits    = 1'b1;
        for (int j = 0; j < bw && fits; j++) begin
          idx = i + j;
          k   = (idx < MAX_COLUMNS_DEF) ? fill_height[idx] : 0;
          if (k >= best_y) begin
            fits = 1'b0;
          end else if (k > tallest) begin
            tallest = k;
          end
        end
        if (fits) begin
          best_x = i;
          best_y = tallest;
        end
      end
      if (best_y + bh > rows) return r;
      for (int i = 0; i < bw; i++) begin
        idx = best_x + i;
        if (idx < cols && idx < MAX_COLUMNS_DEF) fill_height[idx] = best_y + bh;
      end
      r.granted      = 1'b1;
      r.column_start = best_x[COL_OUT_W-1:0];
      r.row_start    = best_y[ROW_OUT_W-1:0];
      return r;
    endfunction

    function void note_request(in_word_t w);
      expected_grants.push_back(place_block(w));
    endfunction

    function void check_grant(out_word_t got);
      out_word_t want;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word granted=%0d col=%0d row=%0d",
                   got.granted, got.column_start, got.row_start);
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted || got.column_start !== want.column_start ||
          got.row_start !== want.row_start) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected granted=%0d col=%0d row=%0d,",
                    " got granted=%0d col=%0d row=%0d"},
                   want.granted, want.column_start, want.row_start,
                   got.granted, got.column_start, got.row_start);
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  placement_checker checker_h = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_stall_left = 0;
  int quiet_cycles = 0;

  int phase_cols [NUM_PHASES] = '{16, 1, 511, 0, 2, 64, 256, 32, 8, 24};
  int phase_rows [NUM_PHASES] = '{64, 256, 511, 8, 1, 256, 200, 32, 300, 48};
  int phase_len  [NUM_PHASES] = '{200, 40, 120, 20, 40, 200, 120, 200, 60, 140};
  int phase_idle [NUM_PHASES] = '{30, 60, 10, 30, 60, 0, 20, 40, 30, 0};

  skyline_atlas_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // accepted words, receiver stall bursts and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) checker_h.note_request(in_data);
      if (out_valid && !out_stall) checker_h.check_grant(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_stall     <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        rx_stall_left <= $urandom_range(0, 14);
        out_stall     <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t make_word(logic op, int bw, int bh);
    in_word_t w;
    w.operation    = op;
    w.block_width  = bw[BLK_W-1:0];
    w.block_height = bh[BLK_W-1:0];
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    in_valid <= 1'b0;
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    checker_h.set_register(idx, val[CFG_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int cols_eff;
    int rows_eff;
    int bw;
    int bh;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases at the reset size
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_word(make_word(OP_ALLOCATE, 0, 0));
    send_word(make_word(OP_ALLOCATE, 256, 0));
    send_word(make_word(OP_ALLOCATE, 1, 1));
    send_word(make_word(OP_CLEAR, 0, 0));
    send_word(make_word(OP_ALLOCATE, 255, 256));
    send_word(make_word(OP_ALLOCATE, 511, 511));
    send_word(make_word(OP_ALLOCATE, 1, 0));
    send_word(make_word(OP_CLEAR, 511, 511));
    send_word(make_word(OP_ALLOCATE, 1, 256));
    send_word(make_word(OP_ALLOCATE, 3, 5));
    send_word(make_word(OP_ALLOCATE, 2, 511));
    send_word(make_word(OP_ALLOCATE, 100, 7));
    send_word(make_word(OP_ALLOCATE, 0, 256));
    send_word(make_word(OP_ALLOCATE, 0, 257));
    send_word(make_word(OP_ALLOCATE, 170, 85));
    send_word(make_word(OP_ALLOCATE, 85, 170));
    send_word(make_word(OP_CLEAR, 0, 0));
    send_word(make_word(OP_ALLOCATE, 257, 0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ATLAS_WIDTH, phase_cols[p]);
      write_reg(CFG_ATLAS_HEIGHT, phase_rows[p]);
      tx_idle_pct = phase_idle[p];
      rx_idle_pct = phase_idle[p];
      cols_eff = (phase_cols[p] > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : phase_cols[p];
      rows_eff = (phase_rows[p] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : phase_rows[p];
      send_word(make_word(OP_CLEAR, 0, 0));
      for (int n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(0, 99) < 5) begin
          send_word(make_word(OP_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511)));
        end else begin
          bw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(0, cols_eff / 3 + 1);
          bh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                            : $urandom_range(0, rows_eff / 3 + 1);
          send_word(make_word(OP_ALLOCATE, bw, bh));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
